/* rtl/core/alss_pkg.sv */
// Shared types and constants for the antialiased line stepper.
`default_nettype none

package alss_pkg;

	// Input kinds carried on the slave-side tuser bit.
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN,
		ST_STEP,
		ST_ADD,
		ST_EMIT
	} alss_state_t;

	// Operations of the shared add/subtract unit.
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alss_alu_op_t;

	// Status the datapath reports to the sequencer.
	typedef struct packed {
		logic in_beat;
		logic in_start;
		logic short_line;
		logic line_active;
		logic axis_aligned;
		logic step_ge;
		logic out_free;
	} alss_status_t;

	// Strobes the sequencer drives into the datapath.
	typedef struct packed {
		logic in_ready;
		logic load;
		logic div_en;
		logic div_first;
		logic fin_en;
		logic step_en;
		logic add_en;
		logic emit_en;
	} alss_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/alss_alu.sv */
// Shared add/subtract and compare unit used by the divider, the threshold and the error stepper.
`default_nettype none

module alss_alu #(
	parameter int WIDTH = 17
) (
	input  alss_pkg::alss_alu_op_t op,
	input  logic [WIDTH-1:0]       a,
	input  logic [WIDTH-1:0]       b,
	output logic [WIDTH-1:0]       res,
	output logic                   ge
);
	import alss_pkg::*;

	logic [WIDTH:0] sum;

	// Subtraction is a plus the inverted b plus one; the carry out then means a >= b.
	always_comb begin
		if (op == ALU_SUB) begin
			sum = {1'b0, a} + {1'b0, ~b} + {{WIDTH{1'b0}}, 1'b1};
		end else begin
			sum = {1'b0, a} + {1'b0, b};
		end
	end

	assign res = sum[WIDTH-1:0];
	assign ge  = (op == ALU_SUB) ? sum[WIDTH] : 1'b0;

endmodule

`default_nettype wire

/* rtl/core/alss_seq.sv */
// Sequencer that walks the shared unit through division, threshold and stepping.
`default_nettype none

module alss_seq #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alss_pkg::alss_status_t status,
	output alss_pkg::alss_ctrl_t   ctrl
);
	import alss_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	alss_state_t      state_q;
	alss_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             div_last;

	// The divider runs one quotient bit per pass, FRAC_BITS+1 passes in all.
	assign div_last = (cnt_q == CNT_W'(FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.in_beat) begin
					if (status.in_start) begin
						state_d = status.short_line ? ST_EMIT : ST_DIV;
					end else begin
						state_d = ST_STEP;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_EMIT;
			end
			ST_STEP: begin
				if (status.line_active && !status.axis_aligned && !status.step_ge) begin
					state_d = ST_ADD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_ADD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.load     = status.in_beat && status.in_start;
			end
			ST_DIV: begin
				ctrl.div_en    = 1'b1;
				ctrl.div_first = (cnt_q == '0);
			end
			ST_FIN: begin
				ctrl.fin_en = 1'b1;
			end
			ST_STEP: begin
				ctrl.step_en = 1'b1;
			end
			ST_ADD: begin
				ctrl.add_en = 1'b1;
			end
			ST_EMIT: begin
				ctrl.emit_en = status.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/antialiased_line_stepper_unit.sv */
// Top level of the antialiased line stepper: stream ports, line state and result register.
`default_nettype none

// Channel   Dir  Beat content (lowest bits first)
// s_*       in   tuser: opcode; tdata: start_x, start_y, end_x, end_y
// m_*       out  tuser: pixel_valid; tdata: pixel_x, pixel_y, intensity; tlast: last_pixel
//
// A start beat for a sloped line passes through its accepting cycle, which loads the line
// state, FRAC_BITS+1 restoring-division passes through the shared add/subtract unit,
// one pass for the threshold 1 - m and an emit cycle that registers its pixel. An
// axis-aligned start goes from its accepting cycle straight to its emit cycle; an advance
// runs a stepping pass, plus one extra pass of the shared unit when the error is
// incremented rather than reduced, before its emit cycle. Reset clears all control state;
// s_tready returns only after the result is registered, and a stalled m_tready holds the
// block in its emit cycle until the register frees.

module antialiased_line_stepper_unit #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16,
	localparam int IDATA_W   = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int ODATA_W   = ((2 * COORD_BITS + 8 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// Slave side. tuser[0]: opcode (start or advance).
	input  logic               s_tvalid,
	output logic               s_tready,
	// tdata: start_x, start_y, end_x, end_y, each COORD_BITS wide, zero padded.
	input  logic [IDATA_W-1:0] s_tdata,
	input  logic [0:0]         s_tuser,
	// Master side. tuser[0]: pixel_valid.
	output logic               m_tvalid,
	input  logic               m_tready,
	// tdata: pixel_x, pixel_y (COORD_BITS each), intensity (8), zero padded.
	output logic [ODATA_W-1:0] m_tdata,
	output logic [0:0]         m_tuser,
	// tlast: last_pixel.
	output logic               m_tlast
);
	import alss_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int ALU_W = (C + 1 > F + 1) ? C + 1 : F + 1;
	localparam int PAD_W = ODATA_W - 2 * C - 8;

	// Fixed-point 1.0 and 0.5 with F fraction bits.
	localparam logic [F:0] FX_ONE  = (F + 1)'(1) << F;
	localparam logic [F:0] FX_HALF = (F + 1)'(1) << (F - 1);

	alss_status_t status;
	alss_ctrl_t   ctrl;

	// Line state.
	logic         line_active_q;
	logic [C-1:0] major_pos_q;
	logic [C-1:0] minor_pos_q;
	logic [C-1:0] major_end_q;
	logic         axes_swapped_q;
	logic         minor_down_q;
	logic         axis_aligned_q;
	logic [F:0]   error_q;
	logic [F:0]   slope_q;
	logic [F:0]   thresh_q;
	logic         nopix_q;
	// Divider working registers.
	logic [C-1:0] rem_q;
	logic [C-1:0] dmaj_q;

	// Result register.
	logic               m_tvalid_q;
	logic [ODATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;
	logic               m_tlast_q;

	// Start decode of the incoming endpoints.
	logic [C-1:0] x1, y1, x2, y2;
	logic [C-1:0] dx, dy;
	logic         in_aligned, in_swapped;
	logic [C-1:0] a1, b1, a2, b2;
	logic [C-1:0] maj_lo, maj_hi, min_lo, min_hi;
	logic         in_minor_down;

	assign x1 = s_tdata[C-1:0];
	assign y1 = s_tdata[2*C-1:C];
	assign x2 = s_tdata[3*C-1:2*C];
	assign y2 = s_tdata[4*C-1:3*C];

	always_comb begin
		dx = (x1 > x2) ? x1 - x2 : x2 - x1;
		dy = (y1 > y2) ? y1 - y2 : y2 - y1;
		in_aligned = (x1 == x2) || (y1 == y2);
		// Equal columns (including a single point) step along the rows.
		if (x1 == x2) begin
			in_swapped = 1'b1;
		end else if (y1 == y2) begin
			in_swapped = 1'b0;
		end else begin
			in_swapped = (dx < dy);
		end
		a1 = in_swapped ? y1 : x1;
		b1 = in_swapped ? x1 : y1;
		a2 = in_swapped ? y2 : x2;
		b2 = in_swapped ? x2 : y2;
		// Order the endpoints so the major coordinate rises.
		if (a1 > a2) begin
			maj_lo = a2;
			maj_hi = a1;
			min_lo = b2;
			min_hi = b1;
		end else begin
			maj_lo = a1;
			maj_hi = a2;
			min_lo = b1;
			min_hi = b2;
		end
		in_minor_down = (min_hi < min_lo);
	end

	// Shared unit operand selection.
	alss_alu_op_t     alu_op;
	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic             alu_ge;

	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = ALU_W'(error_q);
		alu_b  = ALU_W'(thresh_q);
		if (ctrl.div_en) begin
			// The first pass divides dmin itself, later passes the doubled remainder.
			alu_a = ctrl.div_first ? ALU_W'(rem_q) : ALU_W'({rem_q, 1'b0});
			alu_b = ALU_W'(dmaj_q);
		end else if (ctrl.fin_en) begin
			alu_a = ALU_W'(FX_ONE);
			alu_b = ALU_W'(slope_q);
		end else if (ctrl.add_en) begin
			alu_op = ALU_ADD;
			alu_b  = ALU_W'(slope_q);
		end
	end

	alss_alu #(
		.WIDTH(ALU_W)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res),
		.ge (alu_ge)
	);

	alss_seq #(
		.FRAC_BITS(F)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl)
	);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		status.in_beat      = s_tvalid && ctrl.in_ready;
		status.in_start     = (s_tuser[0] == OP_START);
		status.short_line   = in_aligned;
		status.line_active  = line_active_q;
		status.axis_aligned = axis_aligned_q;
		status.step_ge      = alu_ge;
		status.out_free     = out_free;
	end

	// Pixel fields taken from the current line state.
	logic             last_now;
	logic [C-1:0]     col_now, row_now;
	logic [F+8:0]     prod;
	logic [7:0]       inten_now;

	always_comb begin
		last_now = (major_pos_q == major_end_q);
		col_now  = axes_swapped_q ? minor_pos_q : major_pos_q;
		row_now  = axes_swapped_q ? major_pos_q : minor_pos_q;
		// 255 * e is e shifted up by eight less e.
		prod = {error_q, 8'h00} - {8'h00, error_q};
		if (axis_aligned_q || prod[F+8]) begin
			inten_now = 8'hFF;
		end else begin
			inten_now = prod[F+7:F];
		end
	end

	// Line state and divider registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q  <= 1'b0;
			major_pos_q    <= '0;
			minor_pos_q    <= '0;
			major_end_q    <= '0;
			axes_swapped_q <= 1'b0;
			minor_down_q   <= 1'b0;
			axis_aligned_q <= 1'b0;
			error_q        <= '0;
			slope_q        <= '0;
			thresh_q       <= '0;
			nopix_q        <= 1'b0;
		end else begin
			if (ctrl.load) begin
				line_active_q  <= 1'b1;
				major_pos_q    <= maj_lo;
				major_end_q    <= maj_hi;
				minor_pos_q    <= min_lo;
				axes_swapped_q <= in_swapped;
				minor_down_q   <= in_minor_down;
				axis_aligned_q <= in_aligned;
				slope_q        <= '0;
				thresh_q       <= FX_ONE;
				error_q        <= in_aligned ? '0 : FX_HALF;
				nopix_q        <= 1'b0;
			end
			if (ctrl.div_en) begin
				slope_q <= {slope_q[F-1:0], alu_ge};
			end
			if (ctrl.fin_en) begin
				thresh_q <= alu_res[F:0];
			end
			if (ctrl.step_en) begin
				nopix_q <= !line_active_q;
				if (line_active_q) begin
					if (axis_aligned_q) begin
						major_pos_q <= major_pos_q + C'(1);
					end else if (alu_ge) begin
						error_q     <= alu_res[F:0];
						major_pos_q <= major_pos_q + C'(1);
						minor_pos_q <= minor_down_q ? minor_pos_q - C'(1)
						                            : minor_pos_q + C'(1);
					end
				end
			end
			if (ctrl.add_en) begin
				error_q     <= alu_res[F:0];
				major_pos_q <= major_pos_q + C'(1);
			end
			if (ctrl.emit_en && !nopix_q && last_now) begin
				line_active_q <= 1'b0;
			end
		end
	end

	// Divider payload registers need no reset.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q  <= min_hi > min_lo ? min_hi - min_lo : min_lo - min_hi;
			dmaj_q <= maj_hi - maj_lo;
		end else if (ctrl.div_en) begin
			// A remainder always stays below dmaj, so C bits hold it.
			rem_q <= alu_ge ? alu_res[C-1:0] : alu_a[C-1:0];
		end
	end

	// Output register: loaded in the emit cycle once the previous beat is gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.emit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_en) begin
			if (nopix_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b0;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= {{PAD_W{1'b0}}, inten_now, row_now, col_now};
				m_tuser_q <= 1'b1;
				m_tlast_q <= last_now;
			end
		end
	end

	assign s_tready   = ctrl.in_ready;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign m_tlast    = m_tlast_q;

endmodule

`default_nettype wire

/* rtl/core/alss_check.sv */
// Port-level checker for the antialiased line stepper, bound to the top level.
`default_nettype none

module alss_check #(
	parameter int COORD_BITS = 10,
	localparam int ODATA_W   = ((2 * COORD_BITS + 8 + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [ODATA_W-1:0] m_tdata,
	input logic [0:0]         m_tuser,
	input logic               m_tlast
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// The block works on one item at a time: after a beat is taken it is busy.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted beat");

	// An advance with no active line reports an empty, all-zero beat.
	a_empty_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tlast)
		else $error("empty result beat carries data");

	// Only a real pixel can close a line.
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("line end flagged on an empty beat");

endmodule

bind antialiased_line_stepper_unit alss_check #(
	.COORD_BITS(COORD_BITS)
) u_alss_check (.*);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the antialiased line stepper unit.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alss_pkg::*;

	// Block geometry at its default parameters. The beat widths follow the
	// same byte rounding the block uses for its stream ports.
	localparam int CB    = 10;
	localparam int FB    = 16;
	localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CB + 8 + 7) / 8) * 8;

	// Fixed-point constants of the error walk.
	localparam logic [FB:0] FX_ONE  = (FB+1)'(1) << FB;
	localparam logic [FB:0] FX_HALF = (FB+1)'(1) << (FB - 1);

	// One pixel beat as it leaves the block.
	typedef struct packed {
		logic          pixel_valid;
		logic [CB-1:0] pixel_x;
		logic [CB-1:0] pixel_y;
		logic [7:0]    intensity;
		logic          last_pixel;
	} pixel_t;

	// Tracks the line walk the block is expected to perform and keeps the
	// pixels it has promised but not yet delivered, oldest first.
	class aa_line_tracker;
		bit            active;
		bit            swapped;
		bit            minor_dn;
		bit            aligned;
		logic [CB-1:0] major;
		logic [CB-1:0] minor;
		logic [CB-1:0] major_stop;
		logic [FB:0]   err;
		logic [FB:0]   slope;
		logic [FB:0]   thresh;
		pixel_t        pending_pixels[$];
		int            errors;

		// Builds the pixel at the current walk position and retires the line
		// once its far endpoint has been reached.
		function pixel_t plot();
			pixel_t        p;
			logic [FB+8:0] prod;
			logic [FB+8:0] scaled;
			prod   = {8'd0, err} * (FB+9)'(255);
			scaled = prod >> FB;
			p.pixel_valid = 1'b1;
			p.pixel_x     = swapped ? minor : major;
			p.pixel_y     = swapped ? major : minor;
			p.intensity   = (aligned || scaled > 255) ? 8'd255 : scaled[7:0];
			p.last_pixel  = (major == major_stop);
			if (p.last_pixel)
				active = 1'b0;
			return p;
		endfunction

		// Called for every accepted input beat.
		function void take_beat(input logic op, input logic [CB-1:0] sx, sy, ex, ey);
			logic [CB-1:0]    a1, b1, a2, b2, t;
			logic [CB-1:0]    dx, dy, dmaj, dmin;
			logic [CB+FB-1:0] quot;
			pixel_t           idle_px;
			if (op == OP_START) begin
				dx = (sx > ex) ? sx - ex : ex - sx;
				dy = (sy > ey) ? sy - ey : ey - sy;
				if (sx == ex) begin
					// Vertical, and also the single-point case.
					aligned = 1'b1;
					swapped = 1'b1;
				end else if (sy == ey) begin
					aligned = 1'b1;
					swapped = 1'b0;
				end else begin
					aligned = 1'b0;
					swapped = (dx < dy);
				end
				if (swapped) begin
					a1 = sy; b1 = sx; a2 = ey; b2 = ex;
				end else begin
					a1 = sx; b1 = sy; a2 = ex; b2 = ey;
				end
				// Walk always runs toward increasing major coordinate.
				if (a1 > a2) begin
					t = a1; a1 = a2; a2 = t;
					t = b1; b1 = b2; b2 = t;
				end
				major      = a1;
				major_stop = a2;
				minor      = b1;
				minor_dn   = (b2 < b1);
				dmaj       = a2 - a1;
				dmin       = minor_dn ? b1 - b2 : b2 - b1;
				if (aligned || dmaj == 0) begin
					slope  = '0;
					thresh = FX_ONE;
					err    = '0;
				end else begin
					quot   = {dmin, {FB{1'b0}}} / {{FB{1'b0}}, dmaj};
					slope  = (quot > FX_ONE) ? FX_ONE : quot[FB:0];
					thresh = FX_ONE - slope;
					err    = FX_HALF;
				end
				active = 1'b1;
				pending_pixels.push_back(plot());
			end else if (!active) begin
				// Advance with no line in flight: an empty beat.
				idle_px = '0;
				pending_pixels.push_back(idle_px);
			end else begin
				if (!aligned) begin
					if (err >= thresh) begin
						err   = err - thresh;
						minor = minor_dn ? minor - CB'(1) : minor + CB'(1);
					end else begin
						err = err + slope;
					end
				end
				major = major + CB'(1);
				pending_pixels.push_back(plot());
			end
		endfunction

		function void flag(input string what, input logic [31:0] want, input logic [31:0] seen);
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
			errors++;
		endfunction

		// Called for every accepted output beat.
		function void match_pixel(input pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: unexpected pixel beat, expected none, got %0h", $time, got);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel_valid !== want.pixel_valid)
				flag("pixel_valid", want.pixel_valid, got.pixel_valid);
			if (got.pixel_x !== want.pixel_x)
				flag("pixel_x", want.pixel_x, got.pixel_x);
			if (got.pixel_y !== want.pixel_y)
				flag("pixel_y", want.pixel_y, got.pixel_y);
			if (got.intensity !== want.intensity)
				flag("intensity", want.intensity, got.intensity);
			if (got.last_pixel !== want.last_pixel)
				flag("last_pixel", want.last_pixel, got.last_pixel);
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	// Clock, reset and block ports. Every input starts at a known value.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;	// start_x, start_y, end_x, end_y
	logic [0:0]       s_tuser  = '0;	// opcode
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;		// pixel_x, pixel_y, intensity
	logic [0:0]       m_tuser;		// pixel_valid
	logic             m_tlast;		// last_pixel

	aa_line_tracker tracker = new();

	// Idle behavior of each side. When a flag is clear that side never
	// waits between beats; the main sequence flips them between phases.
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	// A nonzero value asks the pixel sink for one long hold-off of that
	// many cycles before its next beat.
	int hold_off  = 0;
	int beats_sent = 0;

	antialiased_line_stepper_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Random filler for the ignored coordinates of advance beats and for
	// the noise beats.
	function automatic logic [IN_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[IN_W-1:0];
	endfunction

	// Offers one beat on the slave side and returns at the edge that takes
	// it. tvalid is only lowered when a gap follows, so back-to-back beats
	// keep it high without a glitch inside one time step.
	task automatic send_beat(input logic op, input logic [IN_W-1:0] data);
		int gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		tracker.take_beat(op, data[CB-1:0], data[2*CB-1:CB], data[3*CB-1:2*CB],
			data[4*CB-1:3*CB]);
		beats_sent++;
	endtask

	// A start beat followed by a number of advance beats.
	task automatic run_line(input logic [CB-1:0] sx, sy, ex, ey, input int advances);
		send_beat(OP_START, {ey, ex, sy, sx});
		repeat (advances)
			send_beat(OP_ADVANCE, rand_word());
	endtask

	// Holds the sender back until every promised pixel has come out. The
	// last beat is withdrawn first so the block cannot take it twice.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Pixel sink: waits a random or requested number of cycles, then takes
	// one beat and checks it. Values are sampled at the accepting edge, so
	// they are the ones the block held going into that edge.
	initial begin : pixel_sink
		int     stall;
		pixel_t got;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_off > 0) begin
				stall    = hold_off;
				hold_off = 0;
			end else begin
				stall = recv_idle ? $urandom_range(0, 12) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.pixel_valid = m_tuser[0];
			got.pixel_x     = m_tdata[CB-1:0];
			got.pixel_y     = m_tdata[2*CB-1:CB];
			got.intensity   = m_tdata[2*CB+7:2*CB];
			got.last_pixel  = m_tlast;
			tracker.match_pixel(got);
		end
	end

	// Main sequence: reset, directed lines, then random line traffic.
	initial begin : stimulus
		int            sx, sy, dx, dy, ex, ey, span, n;
		bit            held;
		bit            drained;
		logic [CB-1:0] cx, cy, qx, qy;
		held    = 1'b0;
		drained = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An advance straight after reset has no line to
		// follow and must give an empty beat.
		send_beat(OP_ADVANCE, rand_word());
		// Horizontal line at the coordinate extremes, cut short by a restart.
		run_line(10'd0, 10'd0, 10'd1023, 10'd0, 2);
		// Vertical line given bottom to top, walked to its end and one past.
		run_line(10'd5, 10'd1023, 10'd5, 10'd1020, 4);
		// Single point at the far corner: one pixel, last, full intensity.
		run_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 1);
		// Diagonal with falling rows: slope of one, error stays at one half.
		run_line(10'd0, 10'd1023, 10'd3, 10'd1020, 3);
		// Steep line, axes swapped, fractional slope.
		run_line(10'd10, 10'd10, 10'd12, 10'd17, 7);
		// Shallow line given right to left so the endpoints get reordered.
		run_line(10'd1023, 10'd0, 10'd1015, 10'd3, 3);

		// Random part, mostly well-formed lines of modest length.
		while (beats_sent < 770) begin
			// Occasionally switch idling on either side for a new phase.
			if ($urandom_range(0, 14) == 0) begin
				send_idle = ($urandom_range(0, 2) != 0);
				recv_idle = ($urandom_range(0, 2) != 0);
			end
			// Long receiver hold-off while beats keep coming: the block
			// fills its result register and has to stall its input.
			if (!held && beats_sent > 250) begin
				hold_off = 150;
				held     = 1'b1;
			end
			// Once, the sender waits until all pixels are out.
			if (!drained && beats_sent > 500) begin
				drain();
				drained = 1'b1;
			end

			case ($urandom_range(0, 9))
				0: begin
					// Noise: any opcode with any payload.
					send_beat(1'($urandom_range(0, 1)), rand_word());
				end
				1: begin
					// Arbitrary long line, usually dropped by a restart.
					run_line(CB'($urandom_range(0, 1023)), CB'($urandom_range(0, 1023)),
						CB'($urandom_range(0, 1023)), CB'($urandom_range(0, 1023)),
						$urandom_range(0, 15));
				end
				default: begin
					sx = $urandom_range(0, 1023);
					sy = $urandom_range(0, 1023);
					dx = $urandom_range(0, 24) - 12;
					dy = $urandom_range(0, 24) - 12;
					case ($urandom_range(0, 7))
						0: dx = 0;
						1: dy = 0;
						2: dy = dx;
						3: dy = -dx;
						default: ;
					endcase
					ex = sx + dx;
					ey = sy + dy;
					cx = CB'(sx);
					cy = CB'(sy);
					qx = CB'(ex);
					qy = CB'(ey);
					// Endpoints may wrap past the edge, so the span comes
					// from the truncated coordinates.
					dx   = int'((cx > qx) ? cx - qx : qx - cx);
					dy   = int'((cy > qy) ? cy - qy : qy - cy);
					span = (dx > dy) ? dx : dy;
					if (span <= 30)
						n = span + $urandom_range(0, 2);
					else
						n = $urandom_range(0, 20);
					if ($urandom_range(0, 7) == 0)
						n = $urandom_range(0, n);
					run_line(cx, cy, qx, qy, n);
				end
			endcase
		end

		drain();
		// Allow for the longest block latency before closing the books.
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("antialiased_line_stepper_unit regression: pass");
		else
			$display("antialiased_line_stepper_unit regression: fail");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("antialiased_line_stepper_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
